>>> sv/itf_pkg.sv
// Package with shared types and constants for the integer to text formatter.
`default_nettype none
package itf_pkg;
    localparam int unsigned VALUE_W = 64;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    localparam logic [2:0] SIZE_32 = 3'd0;
    localparam logic [2:0] SIZE_16 = 3'd1;
    localparam logic [2:0] SIZE_8  = 3'd2;
    localparam logic [2:0] SIZE_64L = 3'd3;
    localparam logic [2:0] SIZE_64V = 3'd4;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_COMMA = 7'h2c;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_XLO   = 7'h78;
    localparam logic [6:0] CH_XUP   = 7'h58;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILL,
        ST_PREFIX,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // Request to the digit unit and its reply.
    typedef struct packed {
        logic        start;
        logic [63:0] mag;
        logic [1:0]  radix;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [3:0]  digit;
        logic        zero;
        logic [63:0] quot;
    } t_div_rsp;

    // Character code of one digit.
    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic up);
        logic [6:0] c;
        begin
            if (d < 4'd10) begin
                c = CH_ZERO + {3'd0, d};
            end else begin
                c = (up ? 7'h41 : 7'h61) + {3'd0, d} - 7'd10;
            end
            return c;
        end
    endfunction
endpackage
`default_nettype wire

>>> sv/itf_digit_unit.sv
// Bit-serial radix unit: produces the next low digit and the quotient.
`default_nettype none
module itf_digit_unit
    import itf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [63:0] r_quot, n_quot;
    logic [3:0]  r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  w_trial;
    logic [4:0]  w_sub;

    // Decimal goes one quotient bit per cycle; powers of two are split off at the start.
    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[2:0], r_quot[63]};
        w_sub   = {1'b0, w_trial} - 5'd10;
        if (i_req.start) begin
            case (i_req.radix)
                RADIX_HEX: begin
                    n_rem = i_req.mag[3:0];
                    n_quot = {4'd0, i_req.mag[63:4]};
                    n_done = 1'b1;
                end
                RADIX_OCT: begin
                    n_rem = {1'b0, i_req.mag[2:0]};
                    n_quot = {3'd0, i_req.mag[63:3]};
                    n_done = 1'b1;
                end
                RADIX_BIN: begin
                    n_rem = {3'd0, i_req.mag[0]};
                    n_quot = {1'b0, i_req.mag[63:1]};
                    n_done = 1'b1;
                end
                default: begin
                    n_quot = i_req.mag;
                    n_rem = 4'd0;
                    n_cnt = 7'd0;
                    n_busy = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            if ({r_rem, r_quot[63]} >= 5'd10) begin
                n_rem = w_sub[3:0];
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.digit = r_rem;
    assign o_rsp.zero  = (r_quot == 64'd0);
    assign o_rsp.quot  = r_quot;
endmodule
`default_nettype wire

>>> sv/itf_text_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
`default_nettype none
module itf_text_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/integer_to_text_formatter_core.sv
// Top level of the integer to text formatter: control, text buffer and output.
//
// Usage: one number with its format fields is taken as an input beat on
// i_valid/o_ready. The text comes back as one output beat per character on
// o_valid/i_ready, most significant character first, with o_last on the
// final character and o_truncated on every character when leading
// characters beyond BUFFER_CHARS were dropped.
// The text is built right to left in the buffer RAM; characters beyond
// BUFFER_CHARS on the left are counted but not stored. Decimal digits come
// from the bit-serial divider, which works through all 64 quotient bits
// before it hands the digit off; hex, octal and binary digits are split off
// directly. Each comma, fill, prefix and sign character is written as its
// own step. Each character is then emitted by a RAM read followed by a load
// of the output register, and a receiver stall holds it there.
// One number is handled at a time; o_ready is high only while idle.
// A stall holds the current character and its flags in the output register.
// Reset (synchronous, active low) returns to idle with nothing pending.
`default_nettype none
module integer_to_text_formatter_core
    import itf_pkg::*;
#(
    parameter int unsigned BUFFER_CHARS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_radix_code,
    input  wire logic        i_upper_case,
    input  wire logic [2:0]  i_size_code,
    input  wire logic        i_unsigned_mode,
    input  wire logic        i_group_commas,
    input  wire logic        i_zero_fill,
    input  wire logic [5:0]  i_pad_width,
    input  wire logic        i_alt_prefix,
    input  wire logic [1:0]  i_sign_mode,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_out_char,
    output logic             o_last,
    output logic             o_truncated
);
    localparam int unsigned AW = $clog2(BUFFER_CHARS);
    localparam int unsigned LW = $clog2(BUFFER_CHARS + 1);
    localparam int unsigned TW = 8;

    t_state r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [TW-1:0] r_total, n_total;
    logic [LW-1:0] r_left, n_left;
    logic [1:0]    r_grp, n_grp;
    logic [1:0]    r_radix;
    logic          r_upper, r_commas, r_zfill, r_prefix, r_neg;
    logic [1:0]    r_sign;
    logic [5:0]    r_width;
    logic          r_comma_pend, n_comma_pend;
    logic          r_rd_pend, n_rd_pend;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, r_otrunc;
    logic          r_pfx_step, n_pfx_step;

    // Operand sizing and magnitude.
    logic [63:0] w_mask, w_v, w_mag;
    logic        w_uns, w_neg;
    logic [6:0]  w_bits_m1;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic          w_we, w_ram_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;
    logic [6:0]    w_wchar;
    logic          w_ofire, w_ifire;

    always_comb begin
        case (i_size_code)
            SIZE_16: begin w_mask = 64'h0000_0000_0000_ffff; w_bits_m1 = 7'd15; end
            SIZE_8:  begin w_mask = 64'h0000_0000_0000_00ff; w_bits_m1 = 7'd7; end
            SIZE_64L, SIZE_64V: begin w_mask = '1; w_bits_m1 = 7'd63; end
            default: begin w_mask = 64'h0000_0000_ffff_ffff; w_bits_m1 = 7'd31; end
        endcase
        w_uns = i_unsigned_mode || (i_radix_code == RADIX_HEX);
        w_v   = i_value & w_mask;
        w_neg = !w_uns && w_v[w_bits_m1[5:0]];
        w_mag = w_neg ? ((64'd0 - w_v) & w_mask) : w_v;
    end

    assign w_ifire = i_valid && o_ready;
    assign w_ofire = r_ovalid && i_ready;
    assign o_ready = (r_state == ST_IDLE);

    itf_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Only the rightmost BUFFER_CHARS characters are stored.
    assign w_ram_we = w_we && (r_total < TW'(BUFFER_CHARS));

    itf_text_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_CHARS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_ifire) n_state = ST_DIV;
            ST_DIV:    if (w_rsp.done && w_rsp.zero && !r_comma_pend) n_state = ST_FILL;
            ST_FILL:   if (!r_zfill || r_total >= {2'd0, r_width}) n_state = ST_PREFIX;
            ST_PREFIX: begin
                if (!r_prefix || r_radix == RADIX_DEC || r_radix == RADIX_BIN
                    || (r_radix == RADIX_OCT) || r_pfx_step) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN:   n_state = ST_EMIT;
            ST_EMIT:   if (w_ofire && o_last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Writes into the buffer, right to left, and read-out control.
    always_comb begin
        n_wptr       = r_wptr;
        n_total      = r_total;
        n_grp        = r_grp;
        n_comma_pend = r_comma_pend;
        n_pfx_step   = r_pfx_step;
        n_rd_pend    = 1'b0;
        n_ovalid     = r_ovalid;
        w_we         = 1'b0;
        w_wchar      = CH_ZERO;
        w_req.start  = 1'b0;
        w_req.mag    = w_mag;
        w_req.radix  = i_radix_code;
        case (r_state)
            ST_IDLE: begin
                if (w_ifire) begin
                    w_req.start  = 1'b1;
                    n_wptr       = AW'(BUFFER_CHARS);
                    n_total      = '0;
                    n_grp        = 2'd0;
                    n_comma_pend = 1'b0;
                    n_pfx_step   = 1'b0;
                end
            end
            ST_DIV: begin
                if (r_comma_pend) begin
                    // Comma between groups, then the next digit is started.
                    w_we         = 1'b1;
                    w_wchar      = CH_COMMA;
                    n_total      = r_total + 1'b1;
                    n_wptr       = r_wptr - 1'b1;
                    n_comma_pend = 1'b0;
                    n_grp        = 2'd0;
                    w_req.start  = 1'b1;
                    w_req.mag    = w_rsp.quot;
                    w_req.radix  = r_radix;
                end else if (w_rsp.done) begin
                    w_we    = 1'b1;
                    n_total = r_total + 1'b1;
                    n_wptr  = r_wptr - 1'b1;
                    w_wchar = digit_char(w_rsp.digit, r_upper);
                    n_grp   = r_grp + 2'd1;
                    if (!w_rsp.zero) begin
                        if (r_commas && r_grp == 2'd2) begin
                            n_comma_pend = 1'b1;
                        end else begin
                            w_req.start = 1'b1;
                            w_req.mag   = w_rsp.quot;
                            w_req.radix = r_radix;
                        end
                    end
                end
            end
            ST_FILL: begin
                if (r_zfill && r_total < {2'd0, r_width}) begin
                    w_we    = 1'b1;
                    w_wchar = CH_ZERO;
                    n_total = r_total + 1'b1;
                    n_wptr  = r_wptr - 1'b1;
                end
            end
            ST_PREFIX: begin
                if (r_prefix && r_radix == RADIX_HEX && !r_pfx_step) begin
                    w_we       = 1'b1;
                    w_wchar    = r_upper ? CH_XUP : CH_XLO;
                    n_total    = r_total + 1'b1;
                    n_wptr     = r_wptr - 1'b1;
                    n_pfx_step = 1'b1;
                end else if (r_prefix && (r_radix == RADIX_HEX || r_radix == RADIX_OCT)) begin
                    w_we    = 1'b1;
                    w_wchar = CH_ZERO;
                    n_total = r_total + 1'b1;
                    n_wptr  = r_wptr - 1'b1;
                end
            end
            ST_SIGN: begin
                if (r_neg || r_sign == SIGN_PLUS || r_sign == SIGN_SPACE) begin
                    w_we    = 1'b1;
                    w_wchar = r_neg ? CH_MINUS : (r_sign == SIGN_PLUS ? CH_PLUS : CH_SPACE);
                    n_total = r_total + 1'b1;
                    n_wptr  = r_wptr - 1'b1;
                end
            end
            ST_EMIT: begin
                // Issue a read when the output register is free or draining.
                if (!r_rd_pend && (!r_ovalid || w_ofire) && r_left != '0) begin
                    n_rd_pend = 1'b1;
                end
                if (w_ofire) n_ovalid = 1'b0;
                if (r_rd_pend) n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    // Read pointer: after the sign the write pointer marks the first character.
    logic [TW-1:0] w_cnt_after;
    logic [AW-1:0] r_rptr, n_rptr;
    always_comb begin
        w_cnt_after = n_total;
        n_rptr = r_rptr;
        n_left = r_left;
        if (r_state == ST_SIGN) begin
            // A truncated text fills the whole buffer and starts at entry zero.
            if (w_cnt_after > TW'(BUFFER_CHARS)) begin
                n_rptr = '0;
                n_left = LW'(BUFFER_CHARS);
            end else begin
                n_rptr = n_wptr;
                n_left = LW'(w_cnt_after);
            end
        end else if (r_state == ST_EMIT && n_rd_pend) begin
            n_rptr = r_rptr + 1'b1;
            n_left = r_left - 1'b1;
        end
    end

    // Reads address the RAM at the current pointer.
    assign w_raddr = r_rptr;

    assign w_waddr = r_wptr - 1'b1;
    assign w_wdata = {1'b0, w_wchar};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_rd_pend <= n_rd_pend;
        end
        r_wptr       <= n_wptr;
        r_total      <= n_total;
        r_grp        <= n_grp;
        r_comma_pend <= n_comma_pend;
        r_pfx_step   <= n_pfx_step;
        r_left       <= n_left;
        r_rptr       <= n_rptr;
        if (w_ifire) begin
            r_radix  <= i_radix_code;
            r_upper  <= i_upper_case;
            r_commas <= i_group_commas;
            r_zfill  <= i_zero_fill;
            r_width  <= i_pad_width;
            r_prefix <= i_alt_prefix;
            r_sign   <= i_sign_mode;
            r_neg    <= w_neg;
        end
        if (r_state == ST_SIGN) begin
            r_otrunc <= (n_total > TW'(BUFFER_CHARS));
        end
        if (r_rd_pend) begin
            r_olast <= (r_left == '0);
        end
        if (r_rd_pend) begin
            o_out_char <= w_rdata[6:0];
        end
    end

    assign o_valid     = r_ovalid;
    assign o_last      = r_olast;
    assign o_truncated = r_otrunc;

`ifndef SYNTH
    // No new number is taken while characters are still due.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while output pending");

    // A stalled character holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_last))
        else $error("output changed under stall");

    // The last character returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> o_ready)
        else $error("not idle after last character");
`endif
endmodule
`default_nettype wire
